FILE: hw/rtl/stt_pkg.sv
// shared types, codes and keyword tables for the source text tokenizer
package stt_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 127;
    localparam int POSITION_BITS_DEF = 16;

    // result queue depth, room for two results per accepted item
    localparam int QUEUE_DEPTH = 4;

    localparam int KW_COUNT = 7;
    localparam int KW_CHARS = 8;
    localparam logic [KW_COUNT-1:0] KW_ALL = '1;

    localparam logic [2:0] KIND_KEYWORD = 3'd0;
    localparam logic [2:0] KIND_IDENT   = 3'd1;
    localparam logic [2:0] KIND_NUMBER  = 3'd2;
    localparam logic [2:0] KIND_OPER    = 3'd3;
    localparam logic [2:0] KIND_DELIM   = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN = 3'd5;

    typedef enum logic [4:0] {
        MODE_START  = 5'b00001,
        MODE_IDENT  = 5'b00010,
        MODE_NUMBER = 5'b00100,
        MODE_OPER   = 5'b01000,
        MODE_DELIM  = 5'b10000
    } mode_t;

    // keyword lengths and text: if else while return int float void
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd2, 3'd4, 3'd5, 3'd6, 3'd3, 3'd5, 3'd4};
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_CHARS] = '{
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
        '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] start;
        logic [6:0]  length;
        logic        ovf;
        logic        last;
    } token_t;

    // results caused by one item, in order
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } step_out_t;

    // keywords still matching after character c at token position p
    function automatic logic [KW_COUNT-1:0] kw_keep(input logic [7:0] c,
                                                   input logic [2:0] p,
                                                   input logic p_ok);
        logic [KW_COUNT-1:0] m;
        m = '0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            m[k] = p_ok && (p < KW_LEN[k]) && (KW_TEXT[k][p] == c);
        end
        return m;
    endfunction

endpackage

FILE: hw/rtl/stt_lexer.sv
// lexer state and per-byte token classification
module stt_lexer #(
    parameter int MAX_TOKEN_LEN = stt_pkg::MAX_TOKEN_LEN_DEF,
    parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         char_in,
    input  logic               end_of_text,
    output stt_pkg::step_out_t step
);
    import stt_pkg::*;

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

    mode_t                  mode_reg, mode_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   ovf_reg, ovf_next;
    logic [KW_COUNT-1:0]    cand_reg, cand_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    function automatic logic [2:0] kind_of(input mode_t m, input logic kw);
        logic [2:0] k;
        case (m)
            MODE_IDENT:  k = kw ? KIND_KEYWORD : KIND_IDENT;
            MODE_NUMBER: k = KIND_NUMBER;
            MODE_OPER:   k = KIND_OPER;
            MODE_DELIM:  k = KIND_DELIM;
            default:     k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic kw_hit(input logic [KW_COUNT-1:0] cand,
                                    input logic [LEN_W-1:0] len, input logic ovf);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (cand[k] && (32'(len) == 32'(KW_LEN[k])))
                hit = 1'b1;
        end
        return hit && !ovf;
    endfunction

    logic is_alpha, is_digit, is_space, is_oper, is_delim;
    logic cont, flush_old, has_unk, has_fin, p_ok;
    mode_t                  mode_post;
    logic [POSITION_BITS-1:0] start_post;
    logic [LEN_W-1:0]       len_post;
    logic                   ovf_post;
    logic [KW_COUNT-1:0]    cand_post;
    token_t tok_old, tok_unk, tok_fin;
    step_out_t so;

    always_comb
    begin
        is_alpha = (char_in >= "a" && char_in <= "z") || (char_in >= "A" && char_in <= "Z");
        is_digit = char_in >= "0" && char_in <= "9";
        is_space = char_in == 8'd32 || (char_in >= 8'd9 && char_in <= 8'd13);
        is_oper  = char_in == "+" || char_in == "-" || char_in == "*" || char_in == "/"
                   || char_in == "=";
        is_delim = char_in == ";" || char_in == "," || char_in == "(" || char_in == ")"
                   || char_in == "{" || char_in == "}";

        cont = (mode_reg == MODE_IDENT && (is_alpha || is_digit))
               || (mode_reg == MODE_NUMBER && is_digit);
        flush_old = (mode_reg != MODE_START) && !cont;
        p_ok = 32'(len_reg) < 32'd8;

        tok_old.kind   = kind_of(mode_reg, kw_hit(cand_reg, len_reg, ovf_reg));
        tok_old.start  = 16'(start_reg);
        tok_old.length = 7'(len_reg);
        tok_old.ovf    = ovf_reg;
        tok_old.last   = 1'b0;

        tok_unk.kind   = KIND_UNKNOWN;
        tok_unk.start  = 16'(pos_reg);
        tok_unk.length = 7'd1;
        tok_unk.ovf    = 1'b0;
        tok_unk.last   = 1'b0;

        // state after this byte, before any end-of-text flush
        mode_post  = mode_reg;
        start_post = start_reg;
        len_post   = len_reg;
        ovf_post   = ovf_reg;
        cand_post  = cand_reg;
        has_unk    = 1'b0;
        if (cont)
        begin
            if (mode_reg == MODE_IDENT)
                cand_post = cand_reg & kw_keep(char_in, len_reg[2:0], p_ok);
            if (len_reg < LEN_W'(MAX_TOKEN_LEN))
                len_post = len_reg + LEN_W'(1);
            else
                ovf_post = 1'b1;
        end
        else
        begin
            mode_post  = MODE_START;
            start_post = pos_reg;
            len_post   = LEN_W'(1);
            ovf_post   = 1'b0;
            cand_post  = KW_ALL;
            if (is_alpha)
            begin
                mode_post = MODE_IDENT;
                cand_post = kw_keep(char_in, 3'd0, 1'b1);
            end
            else if (is_digit)
                mode_post = MODE_NUMBER;
            else if (is_oper)
                mode_post = MODE_OPER;
            else if (is_delim)
                mode_post = MODE_DELIM;
            else
            begin
                len_post = '0;
                has_unk  = !is_space;
            end
        end

        has_fin = end_of_text && (mode_post != MODE_START);
        tok_fin.kind   = kind_of(mode_post, kw_hit(cand_post, len_post, ovf_post));
        tok_fin.start  = 16'(start_post);
        tok_fin.length = 7'(len_post);
        tok_fin.ovf    = ovf_post;
        tok_fin.last   = 1'b0;

        // pack up to two results in order
        so.first  = tok_fin;
        so.second = tok_fin;
        so.count  = {1'b0, has_fin};
        if (flush_old)
        begin
            so.first  = tok_old;
            so.second = has_unk ? tok_unk : tok_fin;
            so.count  = (has_unk || has_fin) ? 2'd2 : 2'd1;
        end
        else if (has_unk)
        begin
            so.first = tok_unk;
            so.count = has_fin ? 2'd2 : 2'd1;
        end
        so.first.last  = so.count == 2'd1;
        so.second.last = so.count == 2'd2;
        step = so;

        if (end_of_text)
        begin
            mode_next  = MODE_START;
            start_next = '0;
            len_next   = '0;
            ovf_next   = 1'b0;
            cand_next  = KW_ALL;
            pos_next   = '0;
        end
        else
        begin
            mode_next  = mode_post;
            start_next = start_post;
            len_next   = len_post;
            ovf_next   = ovf_post;
            cand_next  = cand_post;
            pos_next   = pos_reg + POSITION_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_START;
            start_reg <= '0;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            cand_reg  <= KW_ALL;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            cand_reg  <= cand_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

FILE: hw/rtl/stt_result_queue.sv
// small result queue taking up to two results per cycle, one out per cycle
module stt_result_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  stt_pkg::step_out_t step,
    input  logic               pop,
    output logic               has_room,
    output logic               not_empty,
    output stt_pkg::token_t    head
);
    import stt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    token_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   push_n;
    logic [PTR_W-1:0]   wr_ptr_1;

    assign push_n    = push ? CNT_W'(step.count) : '0;
    assign wr_ptr_1  = wr_ptr_reg + PTR_W'(1);
    assign count_next = count_reg + push_n - CNT_W'(pop);
    assign has_room  = count_reg <= CNT_W'(QUEUE_DEPTH - 2);
    assign not_empty = count_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && step.count != 2'd0)
            entry_reg[wr_ptr_reg] <= step.first;
        if (push && step.count == 2'd2)
            entry_reg[wr_ptr_1] <= step.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

FILE: hw/rtl/source_text_tokenizer_core.sv
// top level of the source text tokenizer: lexer plus result queue
// a result is written into the result queue when the byte that ends it is accepted
// throughput: one byte per cycle while the queue has room; a byte causing two results fills two queue entries
// the four-entry result queue takes bytes while it has room for two results
// reset: asynchronous active low, lexer back to start, position zero, queue empty
module source_text_tokenizer_core #(
    parameter int MAX_TOKEN_LEN = stt_pkg::MAX_TOKEN_LEN_DEF,
    parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // end_of_text
    // token results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] token_start, [22:16] token_length,
                                   // [23] length_overflow
    output logic [2:0]  m_tuser,   // [2:0] token_kind
    output logic        m_tlast    // last_of_run
);
    import stt_pkg::*;

    logic      in_accept;
    logic      out_accept;
    step_out_t step;
    token_t    head;

    // an item is taken whenever the queue can hold both possible results
    assign in_accept  = s_tvalid && s_tready;
    assign out_accept = m_tvalid && m_tready;

    stt_lexer #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .POSITION_BITS (POSITION_BITS)
    ) u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .char_in     (s_tdata),
        .end_of_text (s_tlast),
        .step        (step)
    );

    // results wait here so input and output stall independently
    stt_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .step      (step),
        .pop       (out_accept),
        .has_room  (s_tready),
        .not_empty (m_tvalid),
        .head      (head)
    );

    assign m_tdata = {head.ovf, head.length, head.start};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

FILE: hw/rtl/stt_checker.sv
// port-level checks for the source text tokenizer, bound to the top level
module stt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import stt_pkg::*;

    // a held result is not dropped
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // input only stalls when results are queued
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty queue");

    // unknown bytes are single-byte tokens without overflow
    a_unknown_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_UNKNOWN |-> m_tdata[22:16] == 7'd1 && !m_tdata[23])
        else $error("unknown token with bad length");

    // an overflowed token is never a keyword
    a_ovf_kw: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[23] |-> m_tuser != KIND_KEYWORD)
        else $error("overflowed token reported as keyword");

endmodule

bind source_text_tokenizer_core stt_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
